// ===== hdl/isotp_receive_reassembler_assert.svh =====
// ---------------------------------------------------------------------------
// isotp receive reassembler assertion macros
// shared property forms for the port checker, clocked on i_clk,
// quiet while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef ISOTP_RECEIVE_REASSEMBLER_ASSERT_SVH
`define ISOTP_RECEIVE_REASSEMBLER_ASSERT_SVH

// same-cycle implication
`define ISOTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ISOTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/isotp_pkg.sv =====
// ---------------------------------------------------------------------------
// isotp_pkg
// types and constants shared by the isotp receive reassembler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package isotp_pkg;

    localparam logic [10:0] FUNC_ID        = 11'h700;
    localparam logic [3:0]  FT_SINGLE      = 4'h0;
    localparam logic [3:0]  FT_FIRST       = 4'h1;
    localparam logic [3:0]  FT_CONSEC      = 4'h2;
    localparam logic [11:0] FF_INLINE_MAX  = 12'd6;
    localparam logic [2:0]  FF_INLINE_CNT  = 3'd6;
    localparam logic [2:0]  SEG_MAX        = 3'd7;
    localparam logic [12:0] CF_BYTES       = 13'd7;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_CONT    = 2'd1,
        KIND_SEQ_ERR = 2'd2
    } t_kind;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_BUSY = 1'b1
    } t_rx_state;

    typedef struct packed {
        logic [10:0]      can_id;
        logic [7:0]       pci;
        logic [7:1][7:0]  data;
    } t_frame;

    typedef struct packed {
        t_kind            kind;
        logic             rfc;
        logic [6:0][7:0]  data;
        logic [2:0]       byte_count;
        logic             done;
        logic [11:0]      length;
    } t_result;

endpackage

// ===== hdl/isotp_if.sv =====
// ---------------------------------------------------------------------------
// isotp channel interfaces
// valid/ready channels for frames, results and the receive id register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface isotp_frame_if;
    logic        valid;
    logic        ready;
    logic [10:0] can_id;
    logic [7:0]  pci_byte;
    logic [7:0]  byte_1;
    logic [7:0]  byte_2;
    logic [7:0]  byte_3;
    logic [7:0]  byte_4;
    logic [7:0]  byte_5;
    logic [7:0]  byte_6;
    logic [7:0]  byte_7;

    modport source (output valid, can_id, pci_byte, byte_1, byte_2, byte_3, byte_4,
                    byte_5, byte_6, byte_7, input ready);
    modport sink (input valid, can_id, pci_byte, byte_1, byte_2, byte_3, byte_4,
                  byte_5, byte_6, byte_7, output ready);
endinterface

interface isotp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        request_flow_control;
    logic [7:0]  out_0;
    logic [7:0]  out_1;
    logic [7:0]  out_2;
    logic [7:0]  out_3;
    logic [7:0]  out_4;
    logic [7:0]  out_5;
    logic [7:0]  out_6;
    logic [2:0]  byte_count;
    logic        message_done;
    logic [11:0] message_length;

    modport source (output valid, kind, request_flow_control, out_0, out_1, out_2, out_3,
                    out_4, out_5, out_6, byte_count, message_done, message_length,
                    input ready);
    modport sink (input valid, kind, request_flow_control, out_0, out_1, out_2, out_3,
                  out_4, out_5, out_6, byte_count, message_done, message_length,
                  output ready);
endinterface

interface isotp_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] own_rx_id;

    modport source (output valid, own_rx_id, input ready);
    modport sink (input valid, own_rx_id, output ready);
endinterface

// ===== hdl/isotp_receive_reassembler.sv =====
// ---------------------------------------------------------------------------
// isotp_receive_reassembler
// streaming iso-tp receive reassembler, one can frame in, at most one
// payload segment or sequence error report out
// ---------------------------------------------------------------------------
// a taken frame waits in the frame register until its result is registered in the result register
// throughput: one frame per cycle, held back only by result back pressure
// the frame register and the result register each hold one request
// reset clears both valid flags, the message state and own_rx_id to 0
`timescale 1ns / 1ps

module isotp_receive_reassembler (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    isotp_frame_if.sink           i_frame,
    isotp_cfg_if.sink             i_cfg,
    isotp_result_if.source        o_result
);
    import isotp_pkg::*;

    logic        r_in_valid;
    t_frame      r_frame;
    logic        r_out_valid;
    t_result     r_out;
    logic [10:0] r_own_id;

    logic        w_advance;
    logic        w_res_valid;
    t_result     w_res;

    assign w_advance      = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_frame.ready  = !r_in_valid || w_advance;
    assign i_cfg.ready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= 11'd0;
        end else if (i_cfg.valid) begin
            r_own_id <= i_cfg.own_rx_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_frame.ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_frame.valid && i_frame.ready) begin
            r_frame.can_id  <= i_frame.can_id;
            r_frame.pci     <= i_frame.pci_byte;
            r_frame.data[1] <= i_frame.byte_1;
            r_frame.data[2] <= i_frame.byte_2;
            r_frame.data[3] <= i_frame.byte_3;
            r_frame.data[4] <= i_frame.byte_4;
            r_frame.data[5] <= i_frame.byte_5;
            r_frame.data[6] <= i_frame.byte_6;
            r_frame.data[7] <= i_frame.byte_7;
        end
    end

    isotp_rx_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_advance),
        .i_frame     (r_frame),
        .i_own_id    (r_own_id),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res_valid;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_result.valid                = r_out_valid;
    assign o_result.kind                 = r_out.kind;
    assign o_result.request_flow_control = r_out.rfc;
    assign o_result.out_0                = r_out.data[0];
    assign o_result.out_1                = r_out.data[1];
    assign o_result.out_2                = r_out.data[2];
    assign o_result.out_3                = r_out.data[3];
    assign o_result.out_4                = r_out.data[4];
    assign o_result.out_5                = r_out.data[5];
    assign o_result.out_6                = r_out.data[6];
    assign o_result.byte_count           = r_out.byte_count;
    assign o_result.message_done         = r_out.done;
    assign o_result.message_length       = r_out.length;

endmodule

// ===== hdl/isotp_rx_core.sv =====
// ---------------------------------------------------------------------------
// isotp_rx_core
// frame decode, sequence check and message state for one registered frame
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module isotp_rx_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  isotp_pkg::t_frame i_frame,
    input  logic [10:0]       i_own_id,
    output logic              o_res_valid,
    output isotp_pkg::t_result o_res
);
    import isotp_pkg::*;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_SF,
        EV_FF,
        EV_CF,
        EV_SEQ_ERR
    } t_evt;

    t_rx_state   r_state;
    t_rx_state   n_state;
    logic [11:0] r_total;
    logic [11:0] n_total;
    logic [12:0] r_rx_count;
    logic [12:0] n_rx_count;
    logic [3:0]  r_prev_idx;
    logic [3:0]  n_prev_idx;

    logic        w_id_hit;
    logic [3:0]  w_ctrl;
    logic [3:0]  w_low;
    logic        w_busy_eff;
    logic [11:0] w_ff_len;
    logic        w_ff_short;
    logic [3:0]  w_expect;
    logic [12:0] w_remaining;
    logic [12:0] w_cf_count;
    logic        w_cf_last;
    t_evt        w_evt;

    logic [6:0][7:0] w_src;
    logic [2:0]      w_keep;

    // decode
    always_comb begin
        w_id_hit    = (i_frame.can_id == i_own_id) ||
                      ((i_frame.can_id == FUNC_ID) && (r_state == ST_IDLE));
        w_ctrl      = i_frame.pci[7:4];
        w_low       = i_frame.pci[3:0];
        w_busy_eff  = (r_state == ST_BUSY) && (w_ctrl != FT_FIRST);
        w_ff_len    = {w_low, i_frame.data[1]};
        w_ff_short  = w_ff_len <= FF_INLINE_MAX;
        w_expect    = r_prev_idx + 4'd1;
        w_remaining = (r_rx_count >= {1'b0, r_total}) ? 13'd0
                                                      : ({1'b0, r_total} - r_rx_count);
        w_cf_count  = r_rx_count + CF_BYTES;
        w_cf_last   = w_cf_count >= {1'b0, r_total};

        priority if (!w_id_hit) begin
            w_evt = EV_NONE;
        end else if (!w_busy_eff) begin
            if (w_ctrl == FT_FIRST) begin
                w_evt = EV_FF;
            end else if (w_ctrl == FT_SINGLE) begin
                w_evt = EV_SF;
            end else begin
                w_evt = EV_NONE;
            end
        end else if (w_low != w_expect) begin
            w_evt = EV_SEQ_ERR;
        end else if (w_ctrl == FT_CONSEC) begin
            w_evt = EV_CF;
        end else begin
            w_evt = EV_NONE;
        end
    end

    // next state
    always_comb begin
        n_state    = r_state;
        n_total    = r_total;
        n_rx_count = r_rx_count;
        n_prev_idx = r_prev_idx;
        if (i_step) begin
            unique case (w_evt)
                EV_FF: begin
                    n_total    = w_ff_len;
                    n_prev_idx = 4'd0;
                    if (w_ff_short) begin
                        n_state    = ST_IDLE;
                        n_rx_count = 13'd0;
                    end else begin
                        n_state    = ST_BUSY;
                        n_rx_count = {10'd0, FF_INLINE_CNT};
                    end
                end
                EV_SEQ_ERR: begin
                    n_state    = ST_IDLE;
                    n_rx_count = 13'd0;
                end
                EV_CF: begin
                    n_prev_idx = w_low;
                    if (w_cf_last) begin
                        n_state    = ST_IDLE;
                        n_rx_count = 13'd0;
                    end else begin
                        n_rx_count = w_cf_count;
                    end
                end
                EV_SF, EV_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    // outputs
    always_comb begin
        o_res_valid      = 1'b0;
        o_res.kind       = KIND_START;
        o_res.rfc        = 1'b0;
        o_res.byte_count = 3'd0;
        o_res.done       = 1'b0;
        o_res.length     = r_total;
        w_src            = '0;
        w_keep           = 3'd0;
        unique case (w_evt)
            EV_FF: begin
                o_res_valid      = 1'b1;
                o_res.rfc        = !w_ff_short;
                o_res.done       = w_ff_short;
                o_res.length     = w_ff_len;
                o_res.byte_count = w_ff_short ? w_ff_len[2:0] : FF_INLINE_CNT;
                w_src            = {8'd0, i_frame.data[7:2]};
                w_keep           = o_res.byte_count;
            end
            EV_SF: begin
                o_res_valid      = 1'b1;
                o_res.done       = 1'b1;
                o_res.byte_count = w_low[3] ? SEG_MAX : w_low[2:0];
                o_res.length     = {9'd0, o_res.byte_count};
                w_src            = i_frame.data;
                w_keep           = o_res.byte_count;
            end
            EV_SEQ_ERR: begin
                o_res_valid = 1'b1;
                o_res.kind  = KIND_SEQ_ERR;
                w_src[0]    = {4'd0, w_low};
                w_src[1]    = {4'd0, w_expect};
                w_keep      = 3'd2;
            end
            EV_CF: begin
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_CONT;
                o_res.done       = w_cf_last;
                o_res.byte_count = (w_remaining >= {10'd0, SEG_MAX}) ? SEG_MAX
                                                                     : w_remaining[2:0];
                w_src            = i_frame.data;
                w_keep           = o_res.byte_count;
            end
            EV_NONE: begin
            end
            default: begin
            end
        endcase
        for (int i = 0; i < 7; i++) begin
            o_res.data[i] = (3'(i) < w_keep) ? w_src[i] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_total    <= 12'd0;
            r_rx_count <= 13'd0;
            r_prev_idx <= 4'd0;
        end else begin
            r_state    <= n_state;
            r_total    <= n_total;
            r_rx_count <= n_rx_count;
            r_prev_idx <= n_prev_idx;
        end
    end

endmodule

// ===== hdl/isotp_rx_checker.sv =====
// ---------------------------------------------------------------------------
// isotp_rx_checker
// port level checks on the result channel of the reassembler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "isotp_receive_reassembler_assert.svh"

module isotp_rx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_kind,
    input logic        i_rfc,
    input logic [7:0]  i_out_0,
    input logic [2:0]  i_byte_count,
    input logic        i_done,
    input logic [11:0] i_len
);
    import isotp_pkg::*;

    `ISOTP_ASSERT_NOW(a_err_no_payload, i_out_valid && (i_kind == KIND_SEQ_ERR), (i_byte_count == 3'd0) && !i_done && !i_rfc, "sequence error carries payload")
    `ISOTP_ASSERT_NOW(a_fc_first_frame, i_out_valid && i_rfc, (i_kind == KIND_START) && (i_byte_count == FF_INLINE_CNT) && !i_done && (i_len > FF_INLINE_MAX), "flow control request without long first frame")
    `ISOTP_ASSERT_NOW(a_cont_nonempty, i_out_valid && (i_kind == KIND_CONT), (i_byte_count != 3'd0) && !i_rfc, "empty continuation segment")
    `ISOTP_ASSERT_NEXT(a_hold_stalled, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kind) && $stable(i_len) && $stable(i_byte_count) && $stable(i_out_0), "stalled result changed")

endmodule

bind isotp_receive_reassembler isotp_rx_checker u_rx_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_kind       (o_result.kind),
    .i_rfc        (o_result.request_flow_control),
    .i_out_0      (o_result.out_0),
    .i_byte_count (o_result.byte_count),
    .i_done       (o_result.message_done),
    .i_len        (o_result.message_length)
);
